### src/stc_pkg.sv
`timescale 1ns / 1ps

package stc_pkg;

    // Field widths
    localparam int SAMPLE_W  = 12;
    localparam int INDEX_W   = 8;
    localparam int COUNT_W   = 8;
    localparam int ACTION_W  = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;

    // Store depth default
    localparam int STORE_DEPTH = 256;

    // Register reset values
    localparam logic [SAMPLE_W-1:0] LOW_THR_RST  = 12'd1024;
    localparam logic [SAMPLE_W-1:0] HIGH_THR_RST = 12'd3071;
    localparam logic [SAMPLE_W-1:0] MID_THR_RST  = 12'd2048;
    localparam logic [COUNT_W-1:0]  PRE_CNT_RST  = 8'd120;
    localparam logic [COUNT_W-1:0]  POST_CNT_RST = 8'd120;
    localparam logic [COUNT_W-1:0]  SEEN_MAX     = 8'd255;

    // Item actions
    localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REARM  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NOP    = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_THR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_CNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_CNT = 3'd4;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SAMPLE_W-1:0] sample;
        logic [INDEX_W-1:0]  read_index;
    } item_t;

    typedef struct packed {
        logic                drive_level;
        logic                captured;
        logic                stored;
        logic [INDEX_W-1:0]  peak_index;
        logic [INDEX_W-1:0]  middle_index;
        logic [INDEX_W-1:0]  write_position;
        logic [SAMPLE_W-1:0] read_data;
    } result_t;

    // Request from trigger control to the sample store
    typedef struct packed {
        logic                take;
        logic                wr_en;
        logic [INDEX_W-1:0]  wr_addr;
        logic [SAMPLE_W-1:0] wr_data;
        logic                rd_en;
        logic [INDEX_W-1:0]  rd_addr;
    } store_req_t;

endpackage

### src/stc_store.sv
`timescale 1ns / 1ps

module stc_store #(
    parameter int STORE_DEPTH = stc_pkg::STORE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  stc_pkg::store_req_t           req,
    output logic [stc_pkg::SAMPLE_W-1:0]  rd_data
);

    localparam int AW = $clog2(STORE_DEPTH);

    logic [stc_pkg::SAMPLE_W-1:0] mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0]       valid_reg;
    logic [stc_pkg::SAMPLE_W-1:0] data_reg;
    logic                         sel_reg;

    // Sample memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            data_reg <= mem[req.rd_addr[AW-1:0]];
        end
    end

    // Written-entry flags; an unwritten entry reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr[AW-1:0]] <= 1'b1;
            end
            if (req.take)
            begin
                sel_reg <= req.rd_en && valid_reg[req.rd_addr[AW-1:0]];
            end
        end
    end

    assign rd_data = sel_reg ? data_reg : '0;

    // Reads and writes only come with an accepted beat
    a_wr_take: assert property (@(posedge clk) disable iff (!rst_n)
        req.wr_en |-> req.take)
        else $error("store write without accepted beat");
    a_rd_take: assert property (@(posedge clk) disable iff (!rst_n)
        req.rd_en |-> (req.take && !req.wr_en))
        else $error("store read without accepted beat or with write");
    a_wr_valid: assert property (@(posedge clk) disable iff (!rst_n)
        req.wr_en |=> valid_reg[$past(req.wr_addr[AW-1:0])])
        else $error("written entry not marked");

endmodule

### src/stc_trigger.sv
`timescale 1ns / 1ps

module stc_trigger #(
    parameter int STORE_DEPTH = stc_pkg::STORE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [stc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [stc_pkg::CFG_DAT_W-1:0]  cfg_data,
    input  logic                           take,
    input  stc_pkg::item_t                 item,
    output stc_pkg::result_t               status,
    output stc_pkg::store_req_t            store_req
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(STORE_DEPTH - 1);

    // Configuration registers
    logic [stc_pkg::SAMPLE_W-1:0] low_thr_reg, high_thr_reg, mid_thr_reg;
    logic [stc_pkg::COUNT_W-1:0]  pre_cnt_reg, post_cnt_reg;

    // Trigger state
    logic [AW-1:0]                wr_ptr_reg, wr_ptr_next;
    logic [stc_pkg::COUNT_W-1:0]  seen_reg, seen_next;
    logic                         peak_found_reg, peak_found_next;
    logic                         mid_found_reg, mid_found_next;
    logic [stc_pkg::COUNT_W-1:0]  remain_reg, remain_next;
    logic                         frozen_reg, frozen_next;
    logic [AW-1:0]                peak_pos_reg, peak_pos_next;
    logic [AW-1:0]                mid_pos_reg, mid_pos_next;
    logic [stc_pkg::SAMPLE_W-1:0] prev_reg, prev_next;
    logic                         drive_reg, drive_next;

    logic                         do_sample;
    logic                         do_read;
    logic [AW-1:0]                prev_idx;
    logic                         armed;

    assign do_sample = take && (item.action == stc_pkg::ACT_SAMPLE) && !frozen_reg;
    assign do_read   = take && (item.action == stc_pkg::ACT_READ)
                       && ({1'b0, item.read_index} < 9'(STORE_DEPTH));
    assign prev_idx  = (wr_ptr_reg == '0) ? LAST : wr_ptr_reg - 1'b1;

    // Next-state for one beat
    always_comb
    begin
        wr_ptr_next     = wr_ptr_reg;
        seen_next       = seen_reg;
        peak_found_next = peak_found_reg;
        mid_found_next  = mid_found_reg;
        remain_next     = remain_reg;
        frozen_next     = frozen_reg;
        peak_pos_next   = peak_pos_reg;
        mid_pos_next    = mid_pos_reg;
        prev_next       = prev_reg;
        drive_next      = drive_reg;
        armed           = 1'b0;

        if (do_sample)
        begin
            if (seen_reg != stc_pkg::SEEN_MAX)
            begin
                seen_next = seen_reg + 1'b1;
            end
            // hysteresis, high side wins
            if (item.sample <= low_thr_reg)
            begin
                drive_next = 1'b1;
            end
            if (item.sample >= high_thr_reg)
            begin
                drive_next = 1'b0;
            end
            armed = (seen_next >= pre_cnt_reg);
            if (armed && !peak_found_reg && (prev_reg >= high_thr_reg)
                && (item.sample < high_thr_reg))
            begin
                peak_found_next = 1'b1;
                peak_pos_next   = prev_idx;
            end
            if (armed && peak_found_next && !mid_found_reg && (prev_reg >= mid_thr_reg)
                && (item.sample < mid_thr_reg))
            begin
                mid_found_next = 1'b1;
                mid_pos_next   = wr_ptr_reg;
            end
            // posttrigger countdown
            if (mid_found_next)
            begin
                if (remain_reg == '0)
                begin
                    frozen_next = 1'b1;
                end
                else
                begin
                    remain_next = remain_reg - 1'b1;
                end
            end
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            prev_next   = item.sample;
        end
        else if (take && (item.action == stc_pkg::ACT_REARM))
        begin
            frozen_next     = 1'b0;
            peak_found_next = 1'b0;
            mid_found_next  = 1'b0;
            seen_next       = '0;
            remain_next     = post_cnt_reg;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_thr_reg  <= stc_pkg::LOW_THR_RST;
            high_thr_reg <= stc_pkg::HIGH_THR_RST;
            mid_thr_reg  <= stc_pkg::MID_THR_RST;
            pre_cnt_reg  <= stc_pkg::PRE_CNT_RST;
            post_cnt_reg <= stc_pkg::POST_CNT_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                stc_pkg::CFG_LOW_THR:  low_thr_reg  <= cfg_data;
                stc_pkg::CFG_HIGH_THR: high_thr_reg <= cfg_data;
                stc_pkg::CFG_MID_THR:  mid_thr_reg  <= cfg_data;
                stc_pkg::CFG_PRE_CNT:  pre_cnt_reg  <= cfg_data[stc_pkg::COUNT_W-1:0];
                stc_pkg::CFG_POST_CNT: post_cnt_reg <= cfg_data[stc_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Trigger state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            seen_reg       <= '0;
            peak_found_reg <= 1'b0;
            mid_found_reg  <= 1'b0;
            remain_reg     <= stc_pkg::POST_CNT_RST;
            frozen_reg     <= 1'b0;
            peak_pos_reg   <= '0;
            mid_pos_reg    <= '0;
            prev_reg       <= '0;
            drive_reg      <= 1'b0;
        end
        else
        begin
            wr_ptr_reg     <= wr_ptr_next;
            seen_reg       <= seen_next;
            peak_found_reg <= peak_found_next;
            mid_found_reg  <= mid_found_next;
            remain_reg     <= remain_next;
            frozen_reg     <= frozen_next;
            peak_pos_reg   <= peak_pos_next;
            mid_pos_reg    <= mid_pos_next;
            prev_reg       <= prev_next;
            drive_reg      <= drive_next;
        end
    end

    // Post-beat status, read data filled in by the store
    always_comb
    begin
        status.drive_level    = drive_next;
        status.captured       = frozen_next;
        status.stored         = do_sample;
        status.peak_index     = stc_pkg::INDEX_W'(peak_pos_next);
        status.middle_index   = stc_pkg::INDEX_W'(mid_pos_next);
        status.write_position = stc_pkg::INDEX_W'(wr_ptr_next);
        status.read_data      = '0;
    end

    always_comb
    begin
        store_req.take    = take;
        store_req.wr_en   = do_sample;
        store_req.wr_addr = stc_pkg::INDEX_W'(wr_ptr_reg);
        store_req.wr_data = item.sample;
        store_req.rd_en   = do_read;
        store_req.rd_addr = item.read_index;
    end

    a_frozen_mid: assert property (@(posedge clk) disable iff (!rst_n)
        frozen_reg |-> mid_found_reg)
        else $error("frozen without middle crossing");
    a_mid_peak: assert property (@(posedge clk) disable iff (!rst_n)
        mid_found_reg |-> peak_found_reg)
        else $error("middle crossing without peak");
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, wr_ptr_reg} <= (AW+1)'(STORE_DEPTH - 1)))
        else $error("write pointer out of range");
    a_frozen_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (frozen_reg && !(take && (item.action == stc_pkg::ACT_REARM)))
        |=> ($stable(wr_ptr_reg) && frozen_reg))
        else $error("frozen capture moved");

endmodule

### src/scope_trigger_capture_top.sv
`timescale 1ns / 1ps
// Channel  | Handshake                  | Payload
// item     | item_valid / item_ready    | item   (action, sample, read_index)
// result   | result_valid / result_ready| result (drive_level .. read_data)
// config   | cfg_write_en               | cfg_index, cfg_data
//
// One beat per cycle while item_ready is high; each result appears in the cycle
// after its item beat, from the output register and the registered memory read.
// Reset: thresholds and counts take their defaults, trigger state clears,
// and all store entries read as zero until written (per-entry flags).
// A stalled result holds the output register; item_ready drops only while
// a result waits and result_ready is low.

module scope_trigger_capture_top #(
    parameter int STORE_DEPTH = stc_pkg::STORE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [stc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [stc_pkg::CFG_DAT_W-1:0]  cfg_data,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  stc_pkg::item_t                 item,
    output logic                           result_valid,
    input  logic                           result_ready,
    output stc_pkg::result_t               result
);

    logic                         take;
    stc_pkg::result_t             status;
    stc_pkg::store_req_t          store_req;
    logic [stc_pkg::SAMPLE_W-1:0] rd_data;
    logic                         out_valid_reg;
    stc_pkg::result_t             out_reg;

    assign item_ready = !out_valid_reg || result_ready;
    assign take       = item_valid && item_ready;

    stc_trigger #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_trigger (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .take         (take),
        .item         (item),
        .status       (status),
        .store_req    (store_req)
    );

    stc_store #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (store_req),
        .rd_data (rd_data)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= status;
        end
    end

    // Read data joins from the memory read register
    always_comb
    begin
        result           = out_reg;
        result.read_data = rd_data;
    end

    assign result_valid = out_valid_reg;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_ready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("stalled result lost");
    a_no_take_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_ready) |-> !take)
        else $error("beat taken while result stalled");
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_valid_reg)
        else $error("accepted beat gave no result");

endmodule
